FILE: hdl/page_free_stack_allocator_macros.svh
// Assertion macros used by the checker file.
`ifndef PAGE_FREE_STACK_ALLOCATOR_MACROS_SVH
`define PAGE_FREE_STACK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define PFSA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define PFSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication, checked through reset as well.
`define PFSA_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/pfsa_pkg.sv
package pfsa_pkg;

    // Address space geometry
    localparam int OFFSET_BITS    = 40;
    localparam int PAGE_BYTES     = 4096;
    localparam int PAGES_PER_FILE = 1024;
    localparam int FREE_DEPTH     = 1024;

    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int FILE_SHIFT = PAGE_SHIFT + $clog2(PAGES_PER_FILE);
    localparam int PAGE_W     = OFFSET_BITS - PAGE_SHIFT;
    localparam int NEXT_W     = PAGE_W + 1;
    localparam int COUNT_W    = $clog2(FREE_DEPTH + 1);
    localparam int ADDR_W     = $clog2(FREE_DEPTH);

    // Result field widths
    localparam int FUNC_W     = 2;
    localparam int FILE_IDX_W = 18;
    localparam int PIF_W      = 10;
    localparam int STATUS_W   = 2;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Function codes on the request channel
    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;

    typedef logic [OFFSET_BITS-1:0] t_off;
    typedef logic [PAGE_W-1:0]      t_page;

    typedef enum logic [1:0] {
        OP_ALLOC,
        OP_FREE,
        OP_LOCATE
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BEYOND    = 2'd1,
        ST_FULL      = 2'd2,
        ST_EXHAUSTED = 2'd3
    } t_status;

    typedef enum logic {
        BS_RUN,
        BS_POP
    } t_bstate;

    // Classified command handed from front to back
    typedef struct packed {
        t_op   op;
        t_off  offset;
        t_page page;
    } t_cmd;

    localparam t_off PIF_MASK = t_off'(PAGES_PER_FILE - 1);

    function automatic t_off page_to_offset(t_page page);
        return {page, {PAGE_SHIFT{1'b0}}};
    endfunction

    function automatic logic [FILE_IDX_W-1:0] file_index_of(t_off offset);
        t_off shifted;
        shifted = offset >> FILE_SHIFT;
        return shifted[FILE_IDX_W-1:0];
    endfunction

    function automatic logic [PIF_W-1:0] page_in_file_of(t_off offset);
        t_off shifted;
        shifted = (offset >> PAGE_SHIFT) & PIF_MASK;
        return shifted[PIF_W-1:0];
    endfunction

endpackage

FILE: hdl/pfsa_req_if.sv
interface pfsa_req_if;
    logic                             valid;
    logic                             ready;
    logic [pfsa_pkg::FUNC_W-1:0]      func;
    logic [pfsa_pkg::OFFSET_BITS-1:0] offset;

    modport source (output valid, func, offset, input ready);
    modport sink (input valid, func, offset, output ready);
endinterface

FILE: hdl/pfsa_rsp_if.sv
interface pfsa_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [pfsa_pkg::OFFSET_BITS-1:0] page_offset;
    logic [pfsa_pkg::FILE_IDX_W-1:0]  file_index;
    logic [pfsa_pkg::PIF_W-1:0]       page_in_file;
    logic [pfsa_pkg::STATUS_W-1:0]    status;

    modport source (output valid, page_offset, file_index, page_in_file, status, input ready);
    modport sink (input valid, page_offset, file_index, page_in_file, status, output ready);
endinterface

FILE: hdl/pfsa_front.sv
module pfsa_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    pfsa_req_if.sink         i_req,
    output logic             o_cmd_valid,
    output pfsa_pkg::t_cmd   o_cmd,
    input  logic             i_cmd_ready
);
    import pfsa_pkg::*;

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic take;

    // Accept when the stage is empty or drains this cycle
    assign i_req.ready = !r_valid || i_cmd_ready;
    assign take        = i_req.valid && i_req.ready;

    // Classify the operation; the unused code acts as locate
    always_comb begin
        n_cmd.offset = i_req.offset;
        n_cmd.page   = i_req.offset[OFFSET_BITS-1:PAGE_SHIFT];
        unique case (i_req.func)
            FUNC_ALLOC: n_cmd.op = OP_ALLOC;
            FUNC_FREE:  n_cmd.op = OP_FREE;
            default:    n_cmd.op = OP_LOCATE;
        endcase
    end

    // Hold the classified transaction until the queue takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_cmd_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;
endmodule

FILE: hdl/pfsa_queue.sv
module pfsa_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    input  pfsa_pkg::t_cmd   i_push_cmd,
    output logic             o_push_ready,
    output logic             o_pop_valid,
    output pfsa_pkg::t_cmd   o_pop_cmd,
    input  logic             i_pop_ready
);
    import pfsa_pkg::*;

    t_cmd              r_entry [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_entry[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Store the entry payload
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_entry[r_wr_ptr] <= i_push_cmd;
        end
    end
endmodule

FILE: hdl/pfsa_back.sv
module pfsa_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    input  pfsa_pkg::t_cmd   i_cmd,
    output logic             o_cmd_ready,
    pfsa_rsp_if.source       o_rsp
);
    import pfsa_pkg::*;

    // Free stack storage with registered read
    t_page             r_stack [FREE_DEPTH];
    t_page             r_rd_data;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;

    t_bstate            r_state;
    t_bstate            n_state;
    logic [COUNT_W-1:0] r_count;
    logic [NEXT_W-1:0]  r_next_page;

    logic                  r_out_valid;
    t_off                  r_out_offset;
    logic [FILE_IDX_W-1:0] r_out_file;
    logic [PIF_W-1:0]      r_out_pif;
    t_status               r_out_status;

    logic    out_free;
    logic    take;
    logic    empty;
    logic    full;
    logic    beyond;
    logic    exhausted;
    logic    pop_issue;
    logic    push;
    logic    bump;
    logic    load;
    logic    do_split;
    t_off    n_offset;
    t_status n_status;

    assign out_free    = !r_out_valid || o_rsp.ready;
    assign o_cmd_ready = (r_state == BS_RUN) && out_free;
    assign take        = i_cmd_valid && o_cmd_ready;

    assign empty     = (r_count == '0);
    assign full      = (r_count == COUNT_W'(FREE_DEPTH));
    assign beyond    = ({1'b0, i_cmd.page} >= r_next_page);
    assign exhausted = r_next_page[PAGE_W];

    assign rd_addr = ADDR_W'(r_count - 1'b1);
    assign wr_addr = r_count[ADDR_W-1:0];

    // Next state: a stack pop waits in BS_POP for read data
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_RUN: begin
                if (take && (i_cmd.op == OP_ALLOC) && !empty) begin
                    n_state = BS_POP;
                end
            end
            BS_POP: n_state = BS_RUN;
            default: n_state = BS_RUN;
        endcase
    end

    // Execute the command and build the result
    always_comb begin
        pop_issue = 1'b0;
        push      = 1'b0;
        bump      = 1'b0;
        load      = 1'b0;
        do_split  = 1'b1;
        n_offset  = i_cmd.offset;
        n_status  = ST_OK;
        unique case (r_state)
            BS_RUN: begin
                if (take) begin
                    unique case (i_cmd.op)
                        OP_ALLOC: begin
                            if (!empty) begin
                                pop_issue = 1'b1;
                            end else if (exhausted) begin
                                load     = 1'b1;
                                do_split = 1'b0;
                                n_offset = '0;
                                n_status = ST_EXHAUSTED;
                            end else begin
                                load     = 1'b1;
                                bump     = 1'b1;
                                n_offset = page_to_offset(r_next_page[PAGE_W-1:0]);
                            end
                        end
                        OP_FREE: begin
                            load = 1'b1;
                            priority if (beyond) begin
                                n_status = ST_BEYOND;
                            end else if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                push = 1'b1;
                            end
                        end
                        default: begin
                            load     = 1'b1;
                            n_status = beyond ? ST_BEYOND : ST_OK;
                        end
                    endcase
                end
            end
            BS_POP: begin
                load     = 1'b1;
                n_offset = page_to_offset(r_rd_data);
            end
            default: begin
                load = 1'b0;
            end
        endcase
    end

    // Stack memory: write on push, read the top every cycle
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_stack[wr_addr] <= i_cmd.page;
        end
        r_rd_data <= r_stack[rd_addr];
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_RUN;
            r_count     <= '0;
            r_next_page <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (push) begin
                r_count <= r_count + 1'b1;
            end else if (pop_issue) begin
                r_count <= r_count - 1'b1;
            end
            if (bump) begin
                r_next_page <= r_next_page + 1'b1;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_offset <= n_offset;
            r_out_file   <= do_split ? file_index_of(n_offset) : '0;
            r_out_pif    <= do_split ? page_in_file_of(n_offset) : '0;
            r_out_status <= n_status;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.page_offset  = r_out_offset;
    assign o_rsp.file_index   = r_out_file;
    assign o_rsp.page_in_file = r_out_pif;
    assign o_rsp.status       = r_out_status;
endmodule

FILE: hdl/page_free_stack_allocator.sv
// Channel  | Dir | Payload                                            | Transaction
// i_req    | in  | func, offset                                       | valid & ready
// o_rsp    | out | page_offset, file_index, page_in_file, status      | valid & ready
//
// Path: a request passes the front register and the command queue before the output
// register; an allocate that pops the free stack also passes through BS_POP.
// Throughput: one transaction per cycle unless o_rsp stalls; a pop from the free stack
// holds the execute stage in BS_POP while the stack memory read port returns data.
// Reset (synchronous, i_rst_n low) empties the free stack and the command queue and
// sets the bump pointer to zero; stack entries need no clearing.
// A stalled o_rsp holds the result; the front register and a two-entry queue take up
// to three more transactions before i_req stalls.
module page_free_stack_allocator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pfsa_req_if.sink   i_req,
    pfsa_rsp_if.source o_rsp
);
    import pfsa_pkg::*;

    logic fr_valid;
    t_cmd fr_cmd;
    logic fr_ready;
    logic q_valid;
    t_cmd q_cmd;
    logic q_ready;

    // Accept and classify requests
    pfsa_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_cmd_valid (fr_valid),
        .o_cmd       (fr_cmd),
        .i_cmd_ready (fr_ready)
    );

    // Decouple front and back
    pfsa_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (fr_valid),
        .i_push_cmd   (fr_cmd),
        .o_push_ready (fr_ready),
        .o_pop_valid  (q_valid),
        .o_pop_cmd    (q_cmd),
        .i_pop_ready  (q_ready)
    );

    // Execute against the free stack and bump pointer
    pfsa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_ready (q_ready),
        .o_rsp       (o_rsp)
    );
endmodule

FILE: hdl/pfsa_checker.sv
`include "page_free_stack_allocator_macros.svh"

module pfsa_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_rsp_valid,
    input logic                            i_rsp_ready,
    input logic [pfsa_pkg::OFFSET_BITS-1:0] i_page_offset,
    input logic [pfsa_pkg::FILE_IDX_W-1:0]  i_file_index,
    input logic [pfsa_pkg::PIF_W-1:0]       i_page_in_file,
    input logic [pfsa_pkg::STATUS_W-1:0]    i_status
);
    import pfsa_pkg::*;

    // Hold a stalled result
    `PFSA_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_page_offset) && $stable(i_status), "stalled result changed")

    // Drop results during reset
    `PFSA_ASSERT_NEXT_ALWAYS(a_rst_idle, i_clk, !i_rst_n, !i_rsp_valid, "result valid after reset")

    // Exhausted space carries an all-zero offset split
    `PFSA_ASSERT_IMPL(a_exh_zero, i_clk, i_rst_n, i_rsp_valid && (i_status == ST_EXHAUSTED), (i_page_offset == '0) && (i_file_index == '0) && (i_page_in_file == '0), "exhausted result not zero")

    // Split fields follow the offset
    `PFSA_ASSERT_IMPL(a_split, i_clk, i_rst_n, i_rsp_valid && (i_status != ST_EXHAUSTED), (i_file_index == file_index_of(i_page_offset)) && (i_page_in_file == page_in_file_of(i_page_offset)), "offset split mismatch")
endmodule

bind page_free_stack_allocator pfsa_checker u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_page_offset  (o_rsp.page_offset),
    .i_file_index   (o_rsp.file_index),
    .i_page_in_file (o_rsp.page_in_file),
    .i_status       (o_rsp.status)
);
